### hdl/ravda_pkg.sv
// ----------------------------------------------------------------------------
// ravda_pkg
// Shared widths, scaling constants and the divider status bundle of the
// rolling average deviation alarm.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ravda_pkg;

   localparam int RAW_W    = 10;   // converter sample
   localparam int TEMP_W   = 9;    // scaled temperature, 0..329
   localparam int MARGIN_W = 8;    // alert margin register

   // raw * 32258 stays below 2^25 for every 10-bit raw value
   localparam int PROD_W   = 25;
   localparam int DEN_W    = 17;   // holds 100000
   localparam int QUO_W    = 9;    // the ring average is known to stay below 512
   localparam int STEP_W   = $clog2(QUO_W);

   localparam logic [PROD_W-1:0]   SCALE_MUL    = 25'd32258;
   localparam logic [DEN_W-1:0]    SCALE_DIV    = 17'd100000;
   localparam logic [MARGIN_W-1:0] MARGIN_RESET = 8'd2;

   // floor(raw * 32258 / 100000) equals (raw * SCALE_RECIP) >> SCALE_SHIFT for
   // every 10-bit raw value: the rounding error of the reciprocal stays below
   // one part in 2^26 over the whole input range
   localparam int                 RECIP_W     = 25;
   localparam int                 SCALE_SHIFT = 26;
   localparam logic [RECIP_W-1:0] SCALE_RECIP = 25'd21647978;

   typedef struct packed {
      logic busy;   // working through quotient bits
      logic done;   // one-cycle pulse, quotient is final
   } div_stat_type;

endpackage

### hdl/ravda_div.sv
// ----------------------------------------------------------------------------
// ravda_div
// Restoring divider, one quotient bit per cycle, most significant bit first.
// Works out the ring average, sum over the non-empty count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ravda_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [ravda_pkg::PROD_W-1:0]   dividend,
   input  logic [ravda_pkg::DEN_W-1:0]    divisor,
   output logic [ravda_pkg::QUO_W-1:0]    quotient,
   output ravda_pkg::div_stat_type        stat
);

   localparam int PAD_W = ravda_pkg::PROD_W - ravda_pkg::DEN_W;

   logic [ravda_pkg::PROD_W-1:0] rem_ff, rem_in;
   logic [ravda_pkg::DEN_W-1:0]  den_ff, den_in;
   logic [ravda_pkg::QUO_W-1:0]  quo_ff, quo_in;
   logic [ravda_pkg::STEP_W-1:0] step_ff, step_in;
   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;

   logic [ravda_pkg::PROD_W-1:0] trial;
   logic                         fits;

   // divisor aligned to the current quotient bit
   assign trial = {{PAD_W{1'b0}}, den_ff} << step_ff;
   assign fits  = (rem_ff >= trial);

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend;
         den_in  = divisor;
         quo_in  = '0;
         step_in = ravda_pkg::STEP_W'(ravda_pkg::QUO_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - trial;
         end
         quo_in = {quo_ff[ravda_pkg::QUO_W-2:0], fits};
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

### hdl/rolling_average_deviation_alarm_core.sv
// An accepted request passes through the update, mean and finish states to rsp_valid;
// the mean state, where the divider works out the ring average, is skipped when every
// entry is empty. A new request is taken only once the last one has been handed over,
// and a result held back by rsp_ready stretches the wait by the stall.
// Reset (synchronous, active high) empties the ring, zeroes sum and slot,
// sets the empty count to the ring depth and the alert margin to 2.
// ----------------------------------------------------------------------------
// rolling_average_deviation_alarm_core
// Scales a converter sample to a temperature, keeps a ring of recent values
// and flags samples that stray from the ring average by more than a margin.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rolling_average_deviation_alarm_core #(
   parameter int RING_DEPTH = 10          // 2..16
) (
   input  logic                              clock,
   input  logic                              reset,
   // sample requests
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ravda_pkg::RAW_W-1:0]       req_raw_sample,
   // results
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ravda_pkg::TEMP_W-1:0]      rsp_temperature,
   output logic [ravda_pkg::TEMP_W-1:0]      rsp_average,
   output logic                              rsp_average_valid,
   output logic                              rsp_alert,
   // alert margin register
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ravda_pkg::MARGIN_W-1:0]    csr_alert_margin
);

   // ring bookkeeping widths follow the depth, the scaling product width does not
   localparam int SLOT_W  = $clog2(RING_DEPTH);
   localparam int SUM_W   = $clog2(RING_DEPTH * 329 + 1);
   localparam int EMPTY_W = $clog2(RING_DEPTH + 1);
   localparam int SPROD_W = ravda_pkg::RAW_W + ravda_pkg::RECIP_W;

   // sequencer
   localparam logic [2:0] ST_IDLE   = 3'd0;  // waiting for a request
   localparam logic [2:0] ST_UPDATE = 3'd2;  // ring, sum and empty count
   localparam logic [2:0] ST_MEAN   = 3'd3;  // divider: sum / filled
   localparam logic [2:0] ST_FINISH = 3'd4;  // compare and hand over

   logic [2:0]                       state_ff, state_in;

   // ring state
   logic [ravda_pkg::TEMP_W-1:0]     ring_ff [RING_DEPTH];
   logic [SLOT_W-1:0]                slot_ff, slot_in;
   logic [SUM_W-1:0]                 sum_ff, sum_in;
   logic [EMPTY_W-1:0]               empty_ff, empty_in;
   logic [ravda_pkg::MARGIN_W-1:0]   margin_ff;

   // per-request working values
   logic [ravda_pkg::TEMP_W-1:0]     temp_ff, temp_in;
   logic [ravda_pkg::TEMP_W-1:0]     avg_ff, avg_in;
   logic                             avg_valid_ff, avg_valid_in;

   // output register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [ravda_pkg::TEMP_W-1:0]     rsp_temp_ff, rsp_avg_ff;
   logic                             rsp_avg_valid_ff, rsp_alert_ff;

   // divider
   logic                             div_start;
   logic [ravda_pkg::PROD_W-1:0]     div_dividend;
   logic [ravda_pkg::DEN_W-1:0]      div_divisor;
   logic [ravda_pkg::QUO_W-1:0]      div_quotient;
   ravda_pkg::div_stat_type          div_stat;

   logic                             req_accept;
   logic                             ring_write;
   logic [ravda_pkg::TEMP_W-1:0]     old_entry;
   logic [EMPTY_W-1:0]               filled;
   logic                             out_free;
   logic                             alert_now;
   logic [ravda_pkg::TEMP_W:0]       upper_bound, lower_test;
   logic [SPROD_W-1:0]               scale_prod;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   // the result register can take a new result once the old one is gone
   assign out_free = !rsp_valid_ff || rsp_ready;

   // sample scaling by reciprocal multiply; the temperature is the top bits
   assign scale_prod = SPROD_W'(req_raw_sample) * SPROD_W'(ravda_pkg::SCALE_RECIP);

   // entry being replaced; slot never leaves 0..RING_DEPTH-1
   assign old_entry = ring_ff[slot_ff];

   // ring update, sum and empty count for this sample
   assign ring_write = (state_ff == ST_UPDATE);
   assign sum_in     = ring_write
                       ? sum_ff - SUM_W'(old_entry) + SUM_W'(temp_ff)
                       : sum_ff;
   assign empty_in   = ring_write
                       ? empty_ff - EMPTY_W'(old_entry == '0) + EMPTY_W'(temp_ff == '0)
                       : empty_ff;
   assign slot_in    = !ring_write ? slot_ff
                       : (slot_ff == SLOT_W'(RING_DEPTH - 1)) ? '0
                       : slot_ff + 1'b1;
   assign filled     = EMPTY_W'(RING_DEPTH) - empty_in;

   // Divider gets the running sum over the non-empty count after the ring
   // update; an empty ring skips it.
   assign div_start    = ring_write && (filled != '0);
   assign div_dividend = ravda_pkg::PROD_W'(sum_in);
   assign div_divisor  = ravda_pkg::DEN_W'(filled);

   // Alert: t > a + m, or t < a - m written as t + m < a so that a margin
   // larger than the average never trips the lower test.
   assign upper_bound = {1'b0, avg_ff} + (ravda_pkg::TEMP_W + 1)'(margin_ff);
   assign lower_test  = {1'b0, temp_ff} + (ravda_pkg::TEMP_W + 1)'(margin_ff);
   assign alert_now   = avg_valid_ff &&
                        (({1'b0, temp_ff} > upper_bound) || (lower_test < {1'b0, avg_ff}));

   always_comb begin
      state_in     = state_ff;
      temp_in      = temp_ff;
      avg_in       = avg_ff;
      avg_valid_in = avg_valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               temp_in  = scale_prod[ravda_pkg::SCALE_SHIFT +: ravda_pkg::TEMP_W];
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            avg_in       = '0;
            avg_valid_in = (filled != '0);
            state_in     = (filled != '0) ? ST_MEAN : ST_FINISH;
         end
         ST_MEAN: begin
            if (div_stat.done) begin
               avg_in   = div_quotient;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         sum_ff       <= '0;
         empty_ff     <= EMPTY_W'(RING_DEPTH);
         margin_ff    <= ravda_pkg::MARGIN_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < RING_DEPTH; i++) begin
            ring_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         sum_ff       <= sum_in;
         empty_ff     <= empty_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            margin_ff <= csr_alert_margin;
         end
         if (ring_write) begin
            ring_ff[slot_ff] <= temp_ff;
         end
      end
      temp_ff      <= temp_in;
      avg_ff       <= avg_in;
      avg_valid_ff <= avg_valid_in;
      if (state_ff == ST_FINISH && out_free) begin
         rsp_temp_ff      <= temp_ff;
         rsp_avg_ff       <= avg_ff;
         rsp_avg_valid_ff <= avg_valid_ff;
         rsp_alert_ff     <= alert_now;
      end
   end

   ravda_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .stat     (div_stat)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_temperature   = rsp_temp_ff;
   assign rsp_average       = rsp_avg_ff;
   assign rsp_average_valid = rsp_avg_valid_ff;
   assign rsp_alert         = rsp_alert_ff;

   // a new request never lands on a divider that is still working
   a_accept_div_idle : assert property (@(posedge clock) disable iff (reset)
      req_accept |-> !div_stat.busy)
      else $error("request accepted while divider busy");

   // divider results only turn up where the sequencer waits for them
   a_done_expected : assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_MEAN))
      else $error("divider done outside the mean state");

   // empty count never exceeds the ring depth
   a_empty_bound : assert property (@(posedge clock) disable iff (reset)
      empty_ff <= EMPTY_W'(RING_DEPTH))
      else $error("empty count beyond ring depth");

   // with no valid average the result carries a zero average and no alert
   a_invalid_quiet : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_average_valid) |-> (!rsp_alert && rsp_average == '0))
      else $error("alert or average without valid average");

endmodule
